/* rtl/worst_fit_block_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// Worst-fit block allocator assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WORST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define WFBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define WFBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define WFBA_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wfba_pkg.sv */
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types and constants of the worst-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package wfba_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int OP_W       = 1;
    localparam int BLK_IDX_W  = 4;
    localparam int SIZE_FLD_W = 16;
    localparam int REQ_NUM_W  = 16;
    localparam int BLK_CNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

    localparam logic [REQ_NUM_W-1:0] REQ_NUM_LAST  = '1;
    localparam logic [REQ_NUM_W-1:0] REQ_NUM_FIRST = REQ_NUM_W'(1);

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [BLK_IDX_W-1:0]  block_index;
        logic [SIZE_FLD_W-1:0] size_value;
    } wfba_in_t;

    typedef struct packed {
        logic [REQ_NUM_W-1:0]  request_number;
        logic [SIZE_FLD_W-1:0] request_size;
        logic                  allocated;
        logic [BLK_IDX_W-1:0]  chosen_block;
        logic [SIZE_FLD_W-1:0] size_before;
        logic [SIZE_FLD_W-1:0] transferred_size;
        logic [SIZE_FLD_W-1:0] remaining_size;
    } wfba_out_t;

endpackage

`default_nettype wire

/* rtl/wfba_mem.sv */
// ----------------------------------------------------------------------------
// wfba_mem
// Free-size table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wfba_mem
    import wfba_pkg::*;
#(
    parameter int DEPTH = NUM_BLOCKS_DEF,
    parameter int WIDTH = SIZE_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/wfba_ctrl.sv */
// ----------------------------------------------------------------------------
// wfba_ctrl
// Load/allocate sequencer: scans the table one entry per cycle, keeps the
// largest fit, writes the remainder back and builds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module wfba_ctrl
    import wfba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF,
    localparam int IDX_W = $clog2(NUM_BLOCKS),
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [BLK_CNT_W-1:0] block_count,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire wfba_in_t             in_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output wfba_out_t                 res_data,
    output logic                      mem_rd_en,
    output logic      [IDX_W-1:0]     mem_rd_addr,
    input  wire logic [SIZE_BITS-1:0] mem_rd_data,
    output logic                      mem_wr_en,
    output logic      [IDX_W-1:0]     mem_wr_addr,
    output logic      [SIZE_BITS-1:0] mem_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } wfba_state_t;

    wfba_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic [REQ_NUM_W-1:0] cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_val_reg, best_val_next;

    logic [31:0]          size_ext, bidx_in_ext, bcnt_ext;
    logic [SIZE_BITS-1:0] in_size;
    logic                 ld_in_range;
    logic [CNT_W-1:0]     n_lim;
    logic [CNT_W-1:0]     idx_plus;
    logic [SIZE_BITS-1:0] rem_val;
    logic [31:0]          req_ext, best_val_ext, rem_ext, best_idx_ext;

    // input size masked to the table width
    assign size_ext    = 32'(in_data.size_value);
    assign in_size     = size_ext[SIZE_BITS-1:0];
    assign bidx_in_ext = 32'(in_data.block_index);
    assign ld_in_range = (bidx_in_ext < NUM_BLOCKS);

    // a count above the table size is clamped
    assign bcnt_ext = 32'(block_count);
    assign n_lim    = (bcnt_ext > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bcnt_ext);

    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);
    assign rem_val  = best_val_reg - req_reg;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        req_next      = req_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        in_ready      = (state_reg == S_IDLE);
        res_valid     = (state_reg == S_DONE);
        mem_rd_en     = 1'b0;
        mem_rd_addr   = '0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = '0;
        mem_wr_data   = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_data.operation == OP_LOAD) begin
                        mem_wr_en   = ld_in_range;
                        mem_wr_addr = bidx_in_ext[IDX_W-1:0];
                        mem_wr_data = in_size;
                    end else begin
                        req_next      = in_size;
                        cnt_next      = (cnt_reg == REQ_NUM_LAST) ? REQ_NUM_FIRST
                                                                  : cnt_reg + REQ_NUM_FIRST;
                        n_next        = n_lim;
                        idx_next      = '0;
                        found_next    = 1'b0;
                        best_idx_next = '0;
                        best_val_next = '0;
                        if (n_lim == '0) begin
                            state_next = S_DONE;
                        end else begin
                            mem_rd_en  = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // rd_data holds entry idx_reg; strict > keeps the lowest index on ties
                if ((mem_rd_data >= req_reg) && (!found_reg || (mem_rd_data > best_val_reg)))
                begin
                    found_next    = 1'b1;
                    best_val_next = mem_rd_data;
                    best_idx_next = idx_reg;
                end
                if (idx_plus < n_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg + IDX_W'(1);
                    idx_next    = idx_reg + IDX_W'(1);
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    mem_wr_en   = found_reg;
                    mem_wr_addr = best_idx_reg;
                    mem_wr_data = rem_val;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        req_reg      <= req_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
    end

    assign req_ext      = 32'(req_reg);
    assign best_val_ext = 32'(best_val_reg);
    assign rem_ext      = 32'(rem_val);
    assign best_idx_ext = 32'(best_idx_reg);

    always_comb begin
        res_data                  = '0;
        res_data.request_number   = cnt_reg;
        res_data.request_size     = req_ext[SIZE_FLD_W-1:0];
        res_data.allocated        = found_reg;
        if (found_reg) begin
            res_data.chosen_block     = best_idx_ext[BLK_IDX_W-1:0];
            res_data.size_before      = best_val_ext[SIZE_FLD_W-1:0];
            res_data.transferred_size = req_ext[SIZE_FLD_W-1:0];
            res_data.remaining_size   = rem_ext[SIZE_FLD_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/worst_fit_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_top
// Worst-fit allocator over a table of free block sizes.
// ----------------------------------------------------------------------------
// A load item writes one entry of the free-size table and returns no item. An
// allocate item scans entries 0 .. block_count-1 (clamped to NUM_BLOCKS),
// picks the largest free size not below the request (lowest index on a tie),
// subtracts the request and returns one result item, or a not-allocated item
// with zeroed block fields. An allocate is accepted, then reads the scanned
// entries one at a time through the table's single read port, then writes
// the remainder back as its result enters the output register.
// One item is in work at a time; the table is written back before the next
// item is taken, so reads never see a stale entry. Results sit in an output
// register, so loads keep flowing while a result waits for m_ready.
// Table entries are not reset: allocate only over entries already loaded.
// The user writes block_count on the cfg port only while the block is idle;
// the block does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module worst_fit_block_allocator_top
    import wfba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration: block_count
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [BLK_CNT_W-1:0] cfg_data,
    // input items
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire wfba_in_t             s_data,
    // result items
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output wfba_out_t                 m_data
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    logic [BLK_CNT_W-1:0] block_count_reg;
    logic                 m_valid_reg, m_valid_next;
    wfba_out_t            m_data_reg;

    logic                 res_valid, res_ready;
    wfba_out_t            res_data;

    logic                 mem_rd_en, mem_wr_en;
    logic [IDX_W-1:0]     mem_rd_addr, mem_wr_addr;
    logic [SIZE_BITS-1:0] mem_rd_data, mem_wr_data;

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= '0;
        end else if (cfg_valid) begin
            block_count_reg <= cfg_data;
        end
    end

    wfba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .block_count (block_count_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    wfba_mem #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (SIZE_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: take a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/wfba_checker.sv */
// ----------------------------------------------------------------------------
// wfba_checker
// Port-level checks of the worst-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "worst_fit_block_allocator_top_macros.svh"

module wfba_checker
    import wfba_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire wfba_out_t m_data
);

    logic                  stalled;
    logic                  fields_clear;
    logic [SIZE_FLD_W-1:0] rem_calc;
    logic                  sizes_ok;

    assign stalled      = m_valid && !m_ready;
    assign fields_clear = (m_data.chosen_block == '0) && (m_data.size_before == '0)
                          && (m_data.transferred_size == '0)
                          && (m_data.remaining_size == '0);
    assign rem_calc     = m_data.size_before - m_data.request_size;
    assign sizes_ok     = (m_data.transferred_size == m_data.request_size)
                          && (m_data.remaining_size == rem_calc);

    `WFBA_ASSERT_RST(a_rst_no_result, !aresetn, !m_valid, "result valid after reset")

    `WFBA_ASSERT_NXT(a_result_held, stalled, m_valid && $stable(m_data), "stalled result changed")

    `WFBA_ASSERT_IMP(a_req_num_nonzero, m_valid, m_data.request_number != '0, "request number zero")

    `WFBA_ASSERT_IMP(a_not_alloc_zero, m_valid && !m_data.allocated, fields_clear, "fields not zero")

    `WFBA_ASSERT_IMP(a_alloc_sizes, m_valid && m_data.allocated, sizes_ok, "sizes inconsistent")

endmodule

bind worst_fit_block_allocator_top wfba_checker u_wfba_checker (.*);

`default_nettype wire
